@@ hdl/csma_difs_cw_tx_gate_defines.svh @@
// Assertion macros used by the checker file of the transmit gate.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef CSMA_DIFS_CW_TX_GATE_DEFINES_SVH
`define CSMA_DIFS_CW_TX_GATE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CDTG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, disabled in reset
`define CDTG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ hdl/cdtg_pkg.sv @@
// Types, codes and helpers of the CSMA transmit gate.
// Used by the step logic, the top level and the checker; depends on nothing.
package cdtg_pkg;

	localparam int unsigned TIME_W   = 40;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned TMO_W    = 32;
	localparam int unsigned CW_W     = 16;
	localparam int unsigned AIR_W    = 24;
	localparam int unsigned IN_W     = 88;
	localparam int unsigned OUT_W    = 24;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0] TIME_MAX    = '1;
	localparam logic [TIME_W-1:0] RSSI_PERIOD = TIME_W'(25);
	localparam logic [CNT_W-1:0]  CNT_MAX     = '1;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_PUSH  = 2'd1,
		FUNC_EVENT = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CAUSE_START    = 3'd0,
		CAUSE_TX_END   = 3'd1,
		CAUSE_RX_END   = 3'd2,
		CAUSE_HDR_ERR  = 3'd3,
		CAUSE_PREAMBLE = 3'd4,
		CAUSE_HDR_OK   = 3'd5
	} cause_t;

	typedef enum logic [1:0] {
		DCD_NONE  = 2'd0,
		DCD_CLEAR = 2'd1,
		DCD_SET   = 2'd2
	} dcd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HDR_TMO  = 2'd0,
		CFG_DATA_TMO = 2'd1,
		CFG_DIFS     = 2'd2
	} cfg_idx_t;

	// packed lowest field last, so a cast of tdata lines up
	typedef struct packed {
		logic [AIR_W-1:0]  head_airtime_ms;
		logic              airtime_locked;
		logic              flush_wanted;
		logic [CW_W-1:0]   cw_ms;
		logic              medium_free;
		logic              radio_in_tx;
		logic [2:0]        cause;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic             tx_allowed;
		logic [CNT_W-1:0] pending_out;
		dcd_t             dcd_command;
		logic             poll_rssi;
		logic             restart_radio;
		logic             send_now;
	} res_t;

	localparam int unsigned ITEM_W = $bits(item_t);
	localparam int unsigned RES_W  = $bits(res_t);

	typedef struct packed {
		logic [TMO_W-1:0] header_timeout_ms;
		logic [TMO_W-1:0] data_timeout_ms;
		logic [CW_W-1:0]  difs_ms;
	} cfg_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

endpackage

@@ hdl/cdtg_step.sv @@
// Gate state registers and the combinational next-state/result logic.
// Depends on cdtg_pkg.
module cdtg_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  cdtg_pkg::func_t func,
	input  cdtg_pkg::item_t item,
	input  cdtg_pkg::cfg_t  cfg,
	output cdtg_pkg::res_t  res
);
	import cdtg_pkg::*;

	logic [CNT_W-1:0]  pending_q, pending_d;
	logic              tx_en_q, tx_en_d;
	logic [TIME_W-1:0] reenable_at_q, reenable_at_d;
	logic [TIME_W-1:0] tx_deadline_q, tx_deadline_d;
	logic [TIME_W-1:0] rssi_next_q, rssi_next_d;
	logic [TIME_W-1:0] free_since_q, free_since_d;
	logic [TIME_W-1:0] cw_start_q, cw_start_d;
	logic [TIME_W-1:0] cw_elapsed_q, cw_elapsed_d;
	logic [CW_W-1:0]   cw_goal_q, cw_goal_d;
	logic              cw_chosen_q, cw_chosen_d;
	logic              flush_q, flush_d;

	logic [TIME_W-1:0] now;
	logic [TIME_W-1:0] tx_dl_new;
	logic [TIME_W-1:0] el_sum;
	logic [CW_W-1:0]   goal_eff;
	logic              can_send;

	assign now       = item.now_ms;
	assign tx_dl_new = sat_add(now, {(TIME_W-AIR_W-1)'(0), item.head_airtime_ms, 1'b0});
	assign goal_eff  = cw_chosen_q ? cw_goal_q : item.cw_ms;
	assign el_sum    = (cw_start_q != '0) ? sat_add(cw_elapsed_q, now - cw_start_q)
	                                      : cw_elapsed_q;
	assign can_send  = (pending_q != '0) && !item.airtime_locked;

	always_comb begin
		pending_d     = pending_q;
		tx_en_d       = tx_en_q;
		reenable_at_d = reenable_at_q;
		tx_deadline_d = tx_deadline_q;
		rssi_next_d   = rssi_next_q;
		free_since_d  = free_since_q;
		cw_start_d    = cw_start_q;
		cw_elapsed_d  = cw_elapsed_q;
		cw_goal_d     = cw_goal_q;
		cw_chosen_d   = cw_chosen_q;
		flush_d       = flush_q;
		res           = '0;
		res.dcd_command = DCD_NONE;
		case (func)
			FUNC_TICK: begin
				if (!item.radio_in_tx) begin
					if (tx_en_q && pending_q != '0) begin
						if (flush_q) begin
							if (!can_send) begin
								flush_d = 1'b0;
							end else begin
								res.send_now  = 1'b1;
								tx_deadline_d = tx_dl_new;
								pending_d     = pending_q - CNT_W'(1);
								if (pending_q == CNT_W'(1))
									flush_d = 1'b0;
							end
						end else begin
							cw_goal_d   = goal_eff;
							cw_chosen_d = 1'b1;
							if (item.medium_free) begin
								if (free_since_q == '0) begin
									free_since_d = now;
								end else if ((now - free_since_q) >=
										{(TIME_W-CW_W)'(0), cfg.difs_ms}) begin
									cw_start_d   = now;
									cw_elapsed_d = el_sum;
									if (el_sum >= {(TIME_W-CW_W)'(0), goal_eff}) begin
										free_since_d = '0;
										cw_start_d   = '0;
										cw_elapsed_d = '0;
										cw_chosen_d  = 1'b0;
										if (item.flush_wanted)
											flush_d = 1'b1;
										if (can_send) begin
											res.send_now  = 1'b1;
											tx_deadline_d = tx_dl_new;
											pending_d     = pending_q - CNT_W'(1);
										end
									end
								end
							end else begin
								free_since_d = '0;
								cw_start_d   = '0;
							end
						end
					end else if (!tx_en_q) begin
						if (now >= reenable_at_q) begin
							tx_en_d         = 1'b1;
							res.dcd_command = DCD_CLEAR;
						end
					end
					if (now > rssi_next_q) begin
						rssi_next_d   = sat_add(now, RSSI_PERIOD);
						res.poll_rssi = 1'b1;
					end
				end else if (now > tx_deadline_q) begin
					res.restart_radio = 1'b1;
				end
			end
			FUNC_PUSH: begin
				if (pending_q != CNT_MAX)
					pending_d = pending_q + CNT_W'(1);
			end
			FUNC_EVENT: begin
				if (item.cause inside {[CAUSE_START:CAUSE_HDR_ERR]}) begin
					res.dcd_command = DCD_CLEAR;
					tx_en_d         = 1'b1;
				end else if (item.cause == CAUSE_PREAMBLE) begin
					res.dcd_command = DCD_SET;
					tx_en_d         = 1'b0;
					flush_d         = 1'b0;
					reenable_at_d   = sat_add(now,
						{(TIME_W-TMO_W)'(0), cfg.header_timeout_ms});
				end else if (item.cause == CAUSE_HDR_OK) begin
					res.dcd_command = DCD_SET;
					tx_en_d         = 1'b0;
					reenable_at_d   = sat_add(now,
						{(TIME_W-TMO_W)'(0), cfg.data_timeout_ms});
				end
			end
			default: begin
			end
		endcase
		res.pending_out = pending_d;
		res.tx_allowed  = tx_en_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			tx_en_q       <= 1'b0;
			reenable_at_q <= TIME_MAX;
			tx_deadline_q <= '0;
			rssi_next_q   <= '0;
			free_since_q  <= '0;
			cw_start_q    <= '0;
			cw_elapsed_q  <= '0;
			cw_goal_q     <= '0;
			cw_chosen_q   <= 1'b0;
			flush_q       <= 1'b0;
		end else if (en) begin
			pending_q     <= pending_d;
			tx_en_q       <= tx_en_d;
			reenable_at_q <= reenable_at_d;
			tx_deadline_q <= tx_deadline_d;
			rssi_next_q   <= rssi_next_d;
			free_since_q  <= free_since_d;
			cw_start_q    <= cw_start_d;
			cw_elapsed_q  <= cw_elapsed_d;
			cw_goal_q     <= cw_goal_d;
			cw_chosen_q   <= cw_chosen_d;
			flush_q       <= flush_d;
		end
	end

endmodule

@@ hdl/csma_difs_cw_tx_gate.sv @@
// An input beat is held in the input register, then its result beat in the result
// register that drives m_tdata. Throughput: one beat per cycle while m_tready does
// not stall the output; the gate state updates in the same cycle an item leaves the
// input register, so the state loop of cdtg_step sets the rate.
// Reset: arst_n clears the gate state (reenable deadline to all ones), the config
// registers and both valid flags; no clearing pass.
module csma_difs_cw_tx_gate (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// now_ms, cause, radio_in_tx, medium_free, cw_ms, flush_wanted, airtime_locked,
	// head_airtime_ms, zero pad
	input  logic [cdtg_pkg::IN_W-1:0]               s_tdata,
	// func
	input  logic [1:0]                              s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// send_now, restart_radio, poll_rssi, dcd_command, pending_out, tx_allowed, zero pad
	output logic [cdtg_pkg::OUT_W-1:0]              m_tdata,
	input  logic                                    cfg_we,
	input  logic [cdtg_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [cdtg_pkg::TMO_W-1:0]              cfg_data
);
	import cdtg_pkg::*;

	logic  v_s1;
	item_t item_s1;
	func_t func_s1;
	logic  m_valid_q;
	res_t  res_q;
	res_t  res_nxt;
	cfg_t  cfg_q;
	logic  adv;

	assign adv      = v_s1 && (!m_valid_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_W-RES_W)'(0), res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HDR_TMO:  cfg_q.header_timeout_ms <= cfg_data;
				CFG_DATA_TMO: cfg_q.data_timeout_ms   <= cfg_data;
				CFG_DIFS:     cfg_q.difs_ms           <= cfg_data[CW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (adv)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
			func_s1 <= func_t'(s_tuser);
		end
		if (adv)
			res_q <= res_nxt;
	end

	cdtg_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.func   (func_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_nxt)
	);

endmodule

@@ hdl/cdtg_checker.sv @@
// Port-level checks of the transmit gate, bound to the top level.
// Depends on cdtg_pkg and csma_difs_cw_tx_gate_defines.svh.
`include "csma_difs_cw_tx_gate_defines.svh"

module cdtg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [cdtg_pkg::OUT_W-1:0]   m_tdata
);
	import cdtg_pkg::*;

	res_t r;
	assign r = res_t'(m_tdata[RES_W-1:0]);

	// stalled result beat holds
	`CDTG_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// a send only happens while transmit is enabled, and never with a dcd change
	`CDTG_ASSERT_NOW(a_send_en, m_tvalid && r.send_now, r.tx_allowed && r.dcd_command == DCD_NONE)
	// watchdog only on a tick during transmit: nothing else fires with it
	`CDTG_ASSERT_NOW(a_restart_alone, m_tvalid && r.restart_radio,
		!r.send_now && !r.poll_rssi && r.dcd_command == DCD_NONE)
	// clearing carrier detect always leaves transmit enabled, setting it disables
	`CDTG_ASSERT_NOW(a_dcd_tx, m_tvalid && r.dcd_command != DCD_NONE,
		r.tx_allowed == (r.dcd_command == DCD_CLEAR))

endmodule

bind csma_difs_cw_tx_gate cdtg_checker u_cdtg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
